>>> sv/drbp_pkg.sv
// Shared types and constants of the dirty register burst packer.
package drbp_pkg;

  localparam int unsigned RegCount  = 128;
  localparam int unsigned AddrW     = 7;
  localparam int unsigned WordW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 5;
  localparam int unsigned PktCntW   = 8;
  localparam int unsigned MaxWords  = 16;
  localparam int unsigned MaxRes    = 4;
  localparam int unsigned ResCntW   = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW   = $clog2(MaxRes);
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [1:0] TypeNone = 2'd0;

  typedef struct packed {
    logic [WordW-1:0]   packet_word;
    logic               packet_end;
    logic [CountW-1:0]  packet_words;
    logic               scan_end;
    logic [PktCntW-1:0] packets_sent;
  } res_t;

  typedef struct packed {
    logic [ResCntW-1:0]   count;
    res_t [MaxRes-1:0]    res;
  } bundle_t;

endpackage

>>> sv/dirty_register_burst_packer.sv
// Top level of the dirty register burst packer.
// One register beat is accepted per cycle while full is low; each beat yields up to four
// result beats (packet words and, after the final register, a closing beat with the packet
// count), which leave at one per cycle through empty and pop. The front end settles the
// whole beat in the cycle it is accepted and writes its results as one bundle into a
// two-entry queue; full rises only when that queue is full, so the sustained input rate is
// one register per cycle as long as results are taken as fast as they are made.
// Users write the word limit via cfg_we_i and cfg_wdata_i only while idle; not enforced.
module dirty_register_burst_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [drbp_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     reg_type_i,
  input  logic [drbp_pkg::ByteW-1:0]     reg_value_i,
  input  logic                           last_register_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [drbp_pkg::WordW-1:0]     packet_word_o,
  output logic                           packet_end_o,
  output logic [drbp_pkg::CountW-1:0]    packet_words_o,
  output logic                           scan_end_o,
  output logic [drbp_pkg::PktCntW-1:0]   packets_sent_o
);

  logic              accept;
  logic              q_wr, q_rd, q_empty;
  drbp_pkg::bundle_t q_wdata, q_rdata;
  drbp_pkg::res_t    res;

  assign accept = push && !full;

  drbp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .reg_type_i      (reg_type_i),
    .reg_value_i     (reg_value_i),
    .last_register_i (last_register_i),
    .wr_o            (q_wr),
    .bundle_o        (q_wdata)
  );

  drbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  drbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign packet_word_o  = res.packet_word;
  assign packet_end_o   = res.packet_end;
  assign packet_words_o = res.packet_words;
  assign scan_end_o     = res.scan_end;
  assign packets_sent_o = res.packets_sent;

endmodule

>>> sv/drbp_front.sv
// Front end: takes one register beat per cycle on accept_i, updates packing state, builds results.
module drbp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drbp_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [1:0]                    reg_type_i,
  input  logic [drbp_pkg::ByteW-1:0]    reg_value_i,
  input  logic                          last_register_i,
  output logic                          wr_o,
  output drbp_pkg::bundle_t             bundle_o
);

  typedef struct packed {
    logic [1:0]                        ot;
    logic [drbp_pkg::CountW-1:0]       cnt;
    logic [drbp_pkg::ByteW-1:0]        hb;
    logic                              hbv;
    logic [drbp_pkg::WordW-1:0]        hw;
    logic [drbp_pkg::PktCntW-1:0]      pc;
    logic [drbp_pkg::ResCntW-1:0]      n;
    drbp_pkg::res_t [drbp_pkg::MaxRes-1:0] em;
  } fst_t;

  logic [drbp_pkg::CountW-1:0]  max_words_q;
  logic [drbp_pkg::AddrW-1:0]   addr_q, addr_d;
  logic [1:0]                   open_type_q;
  logic [drbp_pkg::CountW-1:0]  word_cnt_q;
  logic [drbp_pkg::ByteW-1:0]   held_byte_q;
  logic                         held_byte_valid_q;
  logic [drbp_pkg::WordW-1:0]   held_word_q;
  logic [drbp_pkg::PktCntW-1:0] pkt_cnt_q, pkt_cnt_d;
  logic [drbp_pkg::CountW-1:0]  limit;
  fst_t                         st;

  function automatic fst_t f_emit(fst_t s, drbp_pkg::res_t r);
    fst_t o;
    o = s;
    if (o.n < drbp_pkg::ResCntW'(drbp_pkg::MaxRes)) begin
      o.em[o.n[drbp_pkg::ResIdxW-1:0]] = r;
      o.n = o.n + 1'b1;
    end
    return o;
  endfunction

  function automatic fst_t f_close(fst_t s);
    fst_t o;
    drbp_pkg::res_t r;
    r.packet_word  = s.hw;
    r.packet_end   = 1'b1;
    r.packet_words = s.cnt;
    r.scan_end     = 1'b0;
    r.packets_sent = '0;
    o = f_emit(s, r);
    if (o.pc != '1) begin
      o.pc = o.pc + 1'b1;
    end
    o.ot  = drbp_pkg::TypeNone;
    o.cnt = '0;
    o.hbv = 1'b0;
    return o;
  endfunction

  function automatic fst_t f_open(fst_t s, logic [1:0] t, logic [drbp_pkg::AddrW-1:0] a,
                                  logic [drbp_pkg::ByteW-1:0] v,
                                  logic [drbp_pkg::CountW-1:0] lim);
    fst_t o;
    o     = s;
    o.hw  = {t[0], a, v};
    o.hbv = 1'b0;
    o.cnt = drbp_pkg::CountW'(1);
    o.ot  = t;
    if (o.cnt >= lim) begin
      o = f_close(o);
    end
    return o;
  endfunction

  function automatic fst_t f_push(fst_t s, logic [drbp_pkg::WordW-1:0] w,
                                  logic [drbp_pkg::CountW-1:0] lim);
    fst_t o;
    drbp_pkg::res_t r;
    r.packet_word  = s.hw;
    r.packet_end   = 1'b0;
    r.packet_words = '0;
    r.scan_end     = 1'b0;
    r.packets_sent = '0;
    o     = f_emit(s, r);
    o.hw  = w;
    o.cnt = o.cnt + 1'b1;
    if (o.cnt >= lim) begin
      o = f_close(o);
    end
    return o;
  endfunction

  function automatic fst_t f_follow(fst_t s, logic [1:0] t, logic [drbp_pkg::ByteW-1:0] v,
                                    logic [drbp_pkg::AddrW-1:0] a,
                                    logic [drbp_pkg::CountW-1:0] lim);
    fst_t o;
    o = s;
    if (t == drbp_pkg::TypeNone) begin
      o = f_close(o);
    end else if (t == o.ot) begin
      o.hb  = v;
      o.hbv = 1'b1;
    end else begin
      o = f_close(o);
      o = f_open(o, t, a, v, lim);
    end
    return o;
  endfunction

  always_comb begin
    if (max_words_q == '0) begin
      limit = drbp_pkg::CountW'(1);
    end else if (max_words_q > drbp_pkg::CountW'(drbp_pkg::MaxWords)) begin
      limit = drbp_pkg::CountW'(drbp_pkg::MaxWords);
    end else begin
      limit = max_words_q;
    end
  end

  always_comb begin
    logic [1:0]                 ty;
    logic [drbp_pkg::ByteW-1:0] hbb;
    drbp_pkg::res_t             rc;
    ty     = drbp_pkg::TypeNone;
    hbb    = '0;
    rc     = '0;
    st.ot  = open_type_q;
    st.cnt = word_cnt_q;
    st.hb  = held_byte_q;
    st.hbv = held_byte_valid_q;
    st.hw  = held_word_q;
    st.pc  = pkt_cnt_q;
    st.n   = '0;
    st.em  = '0;
    if (st.ot == drbp_pkg::TypeNone) begin
      if (reg_type_i != drbp_pkg::TypeNone) begin
        st = f_open(st, reg_type_i, addr_q, reg_value_i, limit);
      end
    end else if (!st.hbv) begin
      st = f_follow(st, reg_type_i, reg_value_i, addr_q, limit);
    end else if (reg_type_i == st.ot) begin
      st.hbv = 1'b0;
      st = f_push(st, {st.hb, reg_value_i}, limit);
    end else begin
      ty  = st.ot;
      hbb = st.hb;
      st  = f_close(st);
      st  = f_open(st, ty, addr_q - 1'b1, hbb, limit);
      if (st.ot != drbp_pkg::TypeNone) begin
        st = f_follow(st, reg_type_i, reg_value_i, addr_q, limit);
      end
    end
    addr_d    = addr_q + 1'b1;
    pkt_cnt_d = st.pc;
    if (last_register_i || addr_q >= drbp_pkg::AddrW'(drbp_pkg::RegCount - 1)) begin
      if (st.ot != drbp_pkg::TypeNone) begin
        if (st.hbv) begin
          ty  = st.ot;
          hbb = st.hb;
          st  = f_close(st);
          st  = f_open(st, ty, addr_q, hbb, limit);
        end
        if (st.ot != drbp_pkg::TypeNone) begin
          st = f_close(st);
        end
      end
      rc.packet_word  = '0;
      rc.packet_end   = 1'b0;
      rc.packet_words = '0;
      rc.scan_end     = 1'b1;
      rc.packets_sent = st.pc;
      st        = f_emit(st, rc);
      addr_d    = '0;
      pkt_cnt_d = '0;
    end
  end

  assign wr_o           = accept_i && (st.n != '0);
  assign bundle_o.count = st.n;
  assign bundle_o.res   = st.em;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_words_q       <= drbp_pkg::CountW'(drbp_pkg::MaxWords);
      addr_q            <= '0;
      open_type_q       <= drbp_pkg::TypeNone;
      word_cnt_q        <= '0;
      held_byte_q       <= '0;
      held_byte_valid_q <= 1'b0;
      held_word_q       <= '0;
      pkt_cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        max_words_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        addr_q            <= addr_d;
        open_type_q       <= st.ot;
        word_cnt_q        <= st.cnt;
        held_byte_q       <= st.hb;
        held_byte_valid_q <= st.hbv;
        held_word_q       <= st.hw;
        pkt_cnt_q         <= pkt_cnt_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_type_q == drbp_pkg::TypeNone) |-> (!held_byte_valid_q && word_cnt_q == '0))
    else $error("Idle packer holds a byte or a word count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_register_i) |=>
      (addr_q == '0 && pkt_cnt_q == '0 && open_type_q == drbp_pkg::TypeNone))
    else $error("Scan did not restart after its final register.");

endmodule

>>> sv/drbp_fifo.sv
// Short queue of result bundles between the front end and the back end.
module drbp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  drbp_pkg::bundle_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output drbp_pkg::bundle_t rdata_o,
  output logic              empty_o
);

  drbp_pkg::bundle_t                 mem_q [drbp_pkg::FifoDepth];
  logic [drbp_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [drbp_pkg::FifoCntW-1:0]     count_q;
  logic                              do_wr, do_rd;

  assign full_o  = (count_q == drbp_pkg::FifoCntW'(drbp_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == drbp_pkg::FifoPtrW'(drbp_pkg::FifoDepth - 1)) ? '0 :
                    wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == drbp_pkg::FifoPtrW'(drbp_pkg::FifoDepth - 1)) ? '0 :
                    rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= drbp_pkg::FifoCntW'(drbp_pkg::FifoDepth))
    else $error("Bundle queue overfilled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Bundle queue lost a write.");

endmodule

>>> sv/drbp_back.sv
// Back end: hands out the results of each bundle one beat at a time.
module drbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  drbp_pkg::bundle_t q_data_i,
  output logic              q_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output drbp_pkg::res_t    res_o
);

  drbp_pkg::bundle_t              cur_q;
  logic [drbp_pkg::ResIdxW-1:0]   idx_q;
  logic                           busy_q;
  logic                           take, last_beat;

  assign empty_o   = !busy_q;
  assign res_o     = cur_q.res[idx_q];
  assign take      = pop_i && busy_q;
  assign last_beat = (drbp_pkg::ResCntW'(idx_q) == cur_q.count - 1'b1);
  assign q_rd_o    = !q_empty_i && (!busy_q || (take && last_beat));

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (q_rd_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (take) begin
        if (last_beat) begin
          busy_q <= 1'b0;
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cur_q.count != '0 && drbp_pkg::ResCntW'(idx_q) < cur_q.count))
    else $error("Result index outside the current bundle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last_beat) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
    else $error("Result beat was not advanced.");

endmodule

>>> bench/dirty_register_burst_packer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the dirty register burst packer: directed rows, then random scans.
module dirty_register_burst_packer_test;

  localparam logic [1:0] ACC_NONE  = drbp_pkg::TypeNone;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;
  localparam logic [1:0] ACC_RMW   = 2'd3;

  typedef enum int {POP_ALWAYS, POP_HALF, POP_QUARTER, POP_MASK} pop_style_e;

  typedef struct packed {
    bit                        limit_write;
    bit [drbp_pkg::CountW-1:0] limit;
    bit [1:0]                  kind;
    bit [drbp_pkg::ByteW-1:0]  value;
    bit                        last;
    bit                        typed;
    drbp_pkg::res_t            outcome;
  } plan_row_t;

  localparam int PLAN_ROWS = 26;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{1'b0, 5'd0,  ACC_READ,  8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'hAB, 1'b0, 1'b1, {16'h80FF, 1'b0, 5'd0, 1'b0, 8'd0}},
    '{1'b0, 5'd0,  ACC_NONE,  8'h00, 1'b0, 1'b1, {16'h00AB, 1'b1, 5'd2, 1'b0, 8'd0}},
    '{1'b0, 5'd0,  ACC_RMW,   8'h12, 1'b1, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_WRITE, 8'h55, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_WRITE, 8'h66, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_RMW,   8'h77, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_RMW,   8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_NONE,  8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_WRITE, 8'h01, 1'b1, 1'b0, '0},
    '{1'b1, 5'd0,  ACC_NONE,  8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h00, 1'b0, 1'b1, {16'h8000, 1'b1, 5'd1, 1'b0, 8'd0}},
    '{1'b0, 5'd0,  ACC_WRITE, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b1, 5'd31, ACC_NONE,  8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h11, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h22, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h33, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h44, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h55, 1'b0, 1'b0, '0},
    '{1'b1, 5'd2,  ACC_NONE,  8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h66, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h77, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h88, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_READ,  8'h99, 1'b1, 1'b0, '0},
    '{1'b0, 5'd0,  ACC_NONE,  8'h00, 1'b1, 1'b1, {16'h0000, 1'b0, 5'd0, 1'b1, 8'd0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [drbp_pkg::CountW-1:0] cfg_wdata_i;
  logic push;
  logic full;
  logic [1:0] reg_type_i;
  logic [drbp_pkg::ByteW-1:0] reg_value_i;
  logic last_register_i;
  logic empty;
  logic pop;
  logic [drbp_pkg::WordW-1:0] packet_word_o;
  logic packet_end_o;
  logic [drbp_pkg::CountW-1:0] packet_words_o;
  logic scan_end_o;
  logic [drbp_pkg::PktCntW-1:0] packets_sent_o;

  dirty_register_burst_packer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .reg_type_i      (reg_type_i),
    .reg_value_i     (reg_value_i),
    .last_register_i (last_register_i),
    .empty           (empty),
    .pop             (pop),
    .packet_word_o   (packet_word_o),
    .packet_end_o    (packet_end_o),
    .packet_words_o  (packet_words_o),
    .scan_end_o      (scan_end_o),
    .packets_sent_o  (packets_sent_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Packer state as the block should hold it.
  bit [drbp_pkg::CountW-1:0]  lim_reg = 5'd16;
  bit [drbp_pkg::AddrW-1:0]   next_addr;
  bit [1:0]                   open_kind;
  bit [drbp_pkg::CountW-1:0]  open_words;
  bit [drbp_pkg::ByteW-1:0]   spare_byte;
  bit                         spare_ok;
  bit [drbp_pkg::WordW-1:0]   pend_word;
  bit [drbp_pkg::PktCntW-1:0] scan_packets;
  int                         step_results;

  drbp_pkg::res_t awaited_words[$];
  int   failures;
  int   live_registers;
  int   burst_left;
  int   hold_ask;

  function automatic bit [drbp_pkg::CountW-1:0] words_cap();
    if (lim_reg == 0) return drbp_pkg::CountW'(1);
    if (lim_reg > drbp_pkg::MaxWords) return drbp_pkg::CountW'(drbp_pkg::MaxWords);
    return lim_reg;
  endfunction

  function automatic void note_result(bit [drbp_pkg::WordW-1:0] w, bit e,
                                      bit [drbp_pkg::CountW-1:0] n, bit s,
                                      bit [drbp_pkg::PktCntW-1:0] p);
    drbp_pkg::res_t r;
    if (step_results >= drbp_pkg::MaxRes) return;
    r.packet_word  = w;
    r.packet_end   = e;
    r.packet_words = n;
    r.scan_end     = s;
    r.packets_sent = p;
    awaited_words.push_back(r);
    step_results++;
  endfunction

  function automatic void close_burst();
    note_result(pend_word, 1'b1, open_words, 1'b0, '0);
    if (scan_packets != 8'd255) scan_packets++;
    open_kind  = ACC_NONE;
    open_words = '0;
    spare_ok   = 1'b0;
  endfunction

  function automatic void open_burst(bit [1:0] k, bit [drbp_pkg::AddrW-1:0] a,
                                     bit [drbp_pkg::ByteW-1:0] v);
    pend_word  = {k[0], a, v};
    spare_ok   = 1'b0;
    open_words = drbp_pkg::CountW'(1);
    open_kind  = k;
    if (open_words >= words_cap()) close_burst();
  endfunction

  function automatic void add_pair(bit [drbp_pkg::WordW-1:0] w);
    note_result(pend_word, 1'b0, '0, 1'b0, '0);
    pend_word = w;
    open_words++;
    if (open_words >= words_cap()) close_burst();
  endfunction

  function automatic void extend_burst(bit [1:0] k, bit [drbp_pkg::ByteW-1:0] v,
                                       bit [drbp_pkg::AddrW-1:0] a);
    if (k == ACC_NONE) begin
      close_burst();
    end else if (k == open_kind) begin
      spare_byte = v;
      spare_ok   = 1'b1;
    end else begin
      close_burst();
      open_burst(k, a, v);
    end
  endfunction

  function automatic void pack_register(bit [1:0] k, bit [drbp_pkg::ByteW-1:0] v, bit last);
    bit [drbp_pkg::AddrW-1:0] a;
    bit [1:0]                 ko;
    bit [drbp_pkg::ByteW-1:0] b;
    a = next_addr;
    step_results = 0;
    if (open_kind == ACC_NONE) begin
      if (k != ACC_NONE) open_burst(k, a, v);
    end else if (!spare_ok) begin
      extend_burst(k, v, a);
    end else if (k == open_kind) begin
      spare_ok = 1'b0;
      add_pair({spare_byte, v});
    end else begin
      // The waiting byte has no partner, so it becomes a packet of its own.
      ko = open_kind;
      b  = spare_byte;
      close_burst();
      open_burst(ko, a - 7'd1, b);
      if (open_kind != ACC_NONE) extend_burst(k, v, a);
    end
    if (last || a == drbp_pkg::AddrW'(drbp_pkg::RegCount - 1)) begin
      if (open_kind != ACC_NONE) begin
        if (spare_ok) begin
          ko = open_kind;
          b  = spare_byte;
          close_burst();
          open_burst(ko, a, b);
        end
        if (open_kind != ACC_NONE) close_burst();
      end
      note_result('0, 1'b0, '0, 1'b1, scan_packets);
      next_addr    = '0;
      scan_packets = '0;
    end else begin
      next_addr++;
    end
  endfunction

  function automatic bit [drbp_pkg::CountW-1:0] pick_limit();
    unique case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd31;
      3: return 5'd16;
      4: return drbp_pkg::CountW'($urandom_range(2, 4));
      default: return drbp_pkg::CountW'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic send_register(bit [1:0] k, bit [drbp_pkg::ByteW-1:0] v, bit last, bit typed,
                               drbp_pkg::res_t outcome);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i) push <= 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    push            <= 1'b1;
    reg_type_i      <= k;
    reg_value_i     <= v;
    last_register_i <= last;
    do @(posedge clk_i); while (full);
    pack_register(k, v, last);
    if (typed) begin
      repeat (step_results) void'(awaited_words.pop_back());
      awaited_words.push_back(outcome);
    end
    live_registers++;
  endtask

  task automatic drain();
    @(negedge clk_i) push <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(bit [drbp_pkg::CountW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    lim_reg = v;
  endtask

  task automatic sweep(int len, bit noise, bit close_it);
    int       run_left;
    bit [1:0] run_kind;
    bit [1:0] k;
    bit       l;
    run_left = 0;
    run_kind = ACC_NONE;
    for (int i = 0; i < len; i++) begin
      if (run_left == 0) begin
        run_kind = ($urandom_range(0, 5) == 0) ? ACC_NONE : 2'($urandom_range(1, 3));
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
      end
      run_left--;
      k = noise ? 2'($urandom_range(0, 3)) : run_kind;
      l = close_it && (i == len - 1);
      if (noise && $urandom_range(0, 19) == 0) l = 1'b1;
      if ($urandom_range(0, 59) == 0) set_limit(pick_limit());
      if (live_registers >= 60 * (hold_ask + 1) && hold_ask < 3) hold_ask++;
      send_register(k, 8'($urandom), l, 1'b0, '0);
    end
  endtask

  // Result side: its own stall pattern, plus long hold-offs on request.
  initial begin
    int         hold_left;
    int         hold_seen;
    int         style_left;
    pop_style_e style;
    bit [7:0]   mask;
    pop = 1'b0;
    hold_left  = 0;
    hold_seen  = 0;
    style_left = 0;
    style      = POP_ALWAYS;
    mask       = 8'hFF;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = pop_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(16, 80);
          mask       = 8'($urandom) | 8'h01;
        end
        style_left--;
        unique case (style)
          POP_ALWAYS:  pop <= 1'b1;
          POP_HALF:    pop <= 1'($urandom_range(0, 1));
          POP_QUARTER: pop <= ($urandom_range(0, 3) == 0);
          default: begin
            pop  <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [drbp_pkg::WordW-1:0] want,
                                      logic [drbp_pkg::WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    drbp_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: result beat with nothing awaited, expected none, got word %h scan_end %b",
                 $time, packet_word_o, scan_end_o);
        failures++;
      end else begin
        want = awaited_words.pop_front();
        check_field("packet_word", want.packet_word, packet_word_o);
        check_field("packet_end", drbp_pkg::WordW'(want.packet_end),
                    drbp_pkg::WordW'(packet_end_o));
        check_field("packet_words", drbp_pkg::WordW'(want.packet_words),
                    drbp_pkg::WordW'(packet_words_o));
        check_field("scan_end", drbp_pkg::WordW'(want.scan_end),
                    drbp_pkg::WordW'(scan_end_o));
        check_field("packets_sent", drbp_pkg::WordW'(want.packets_sent),
                    drbp_pkg::WordW'(packets_sent_o));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** dirty_register_burst_packer: FAILED **");
    $finish;
  end

  initial begin
    int waited;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    push            = 1'b0;
    reg_type_i      = ACC_NONE;
    reg_value_i     = '0;
    last_register_i = 1'b0;
    failures        = 0;
    live_registers  = 0;
    burst_left      = 0;
    hold_ask        = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].limit_write) begin
        set_limit(PLAN[i].limit);
      end else begin
        send_register(PLAN[i].kind, PLAN[i].value, PLAN[i].last, PLAN[i].typed,
                      PLAN[i].outcome);
      end
    end

    live_registers = 0;
    while (live_registers < 60) begin
      if ($urandom_range(0, 2) == 0) set_limit(pick_limit());
      sweep($urandom_range(3, 40), $urandom_range(0, 4) == 0, 1'b1);
    end
    // A scan that runs to the top address with no last-register flag.
    set_limit(pick_limit());
    sweep(drbp_pkg::RegCount, 1'b0, 1'b0);

    @(negedge clk_i) push <= 1'b0;
    waited = 0;
    while (awaited_words.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (awaited_words.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, awaited_words.size());
      failures += awaited_words.size();
    end
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("** dirty_register_burst_packer: PASSED **");
    end else begin
      $display("** dirty_register_burst_packer: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/drbp_pkg.sv
sv/drbp_front.sv
sv/drbp_fifo.sv
sv/drbp_back.sv
sv/dirty_register_burst_packer.sv
bench/dirty_register_burst_packer_test.sv
